@@ hdl/sdg_pkg.sv @@
// sdg_pkg: shared types and constants for the step/direction generator
// holds the request and response word structs and the operation codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sdg_pkg;

   localparam int POSITION_BITS_DEFAULT = 32;
   localparam int HALF_PERIOD_BITS      = 24;
   localparam int ELAPSED_BITS          = 28;
   localparam int HOMING_LIMIT_BITS     = 27;

   localparam logic [HALF_PERIOD_BITS-1:0]  HALF_PERIOD_RESET  = 24'd1000;
   localparam logic [HOMING_LIMIT_BITS-1:0] HOMING_LIMIT_RESET = 27'd6000;
   localparam logic [ELAPSED_BITS-1:0]      ELAPSED_MAX        = '1;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_TARGET = 2'd1,
      OP_HOME   = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] target_step;
      logic               sensor_level;
   } req_word_type;

   typedef struct packed {
      logic               step_level;
      logic               direction;
      logic signed [31:0] position;
      logic               moving;
      logic               homing_busy;
   } rsp_word_type;

   // six times the half period as shift and add
   function automatic logic [HOMING_LIMIT_BITS-1:0] homing_limit(
      input logic [HALF_PERIOD_BITS-1:0] half_period
   );
      logic [HOMING_LIMIT_BITS-1:0] wide;
      wide = HOMING_LIMIT_BITS'(half_period);
      return (wide << 2) + (wide << 1);
   endfunction

endpackage

`default_nettype wire

@@ hdl/sdg_core.sv @@
// sdg_core: motion and homing state with its combinational update logic
// depends on sdg_pkg; produces the response word from the updated state
`timescale 1ns / 1ps
`default_nettype none

module sdg_core
   import sdg_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         fire,
   input  wire req_word_type                 word,
   input  wire logic [HALF_PERIOD_BITS-1:0]  half_period,
   input  wire logic [HOMING_LIMIT_BITS-1:0] home_limit,
   output rsp_word_type                      result
);

   logic signed [POSITION_BITS-1:0] position_ff, position_in;
   logic signed [POSITION_BITS-1:0] target_ff, target_in;
   logic [ELAPSED_BITS-1:0]         elapsed_ff, elapsed_in;
   logic                            phase_ff, phase_in;
   logic                            dir_ff, dir_in;
   logic                            homing_ff, homing_in;
   logic                            home_level_ff, home_level_in;

   logic [ELAPSED_BITS-1:0]         elapsed_inc;
   logic signed [POSITION_BITS-1:0] new_target;
   logic signed [63:0]              target_wide;
   logic signed [63:0]              position_wide;
   logic                            at_target;

   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff
                                                    : elapsed_ff + ELAPSED_BITS'(1);
   assign target_wide = 64'(word.target_step);
   assign new_target  = target_wide[POSITION_BITS-1:0];
   assign at_target   = (position_ff == target_ff);

   always_comb begin
      position_in   = position_ff;
      target_in     = target_ff;
      elapsed_in    = elapsed_ff;
      phase_in      = phase_ff;
      dir_in        = dir_ff;
      homing_in     = homing_ff;
      home_level_in = home_level_ff;
      case (word.operation)
         OP_TICK: begin
            if (homing_ff) begin
               if (!phase_ff && (word.sensor_level != home_level_ff)) begin
                  homing_in   = 1'b0;
                  position_in = '0;
                  elapsed_in  = '0;
               end else if (elapsed_inc > ELAPSED_BITS'(home_limit)) begin
                  elapsed_in = '0;
                  phase_in   = !phase_ff;
               end else begin
                  elapsed_in = elapsed_inc;
               end
            end else if (!at_target) begin
               if (elapsed_inc > ELAPSED_BITS'(half_period)) begin
                  elapsed_in = '0;
                  phase_in   = !phase_ff;
                  // falling edge of the step level
                  if (phase_ff) begin
                     if (target_ff > position_ff) begin
                        position_in = position_ff + POSITION_BITS'(1);
                     end else begin
                        position_in = position_ff - POSITION_BITS'(1);
                     end
                  end
               end else begin
                  elapsed_in = elapsed_inc;
               end
            end else begin
               elapsed_in = elapsed_inc;
            end
         end
         OP_TARGET: begin
            if (!homing_ff && at_target) begin
               target_in = new_target;
               dir_in    = (new_target > position_ff);
            end
         end
         OP_HOME: begin
            if (!homing_ff) begin
               homing_in     = 1'b1;
               home_level_in = word.sensor_level;
               dir_in        = 1'b1;
               phase_in      = 1'b0;
               elapsed_in    = ELAPSED_MAX;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         target_ff     <= '0;
         elapsed_ff    <= '0;
         phase_ff      <= 1'b0;
         dir_ff        <= 1'b0;
         homing_ff     <= 1'b0;
         home_level_ff <= 1'b0;
      end else if (fire) begin
         position_ff   <= position_in;
         target_ff     <= target_in;
         elapsed_ff    <= elapsed_in;
         phase_ff      <= phase_in;
         dir_ff        <= dir_in;
         homing_ff     <= homing_in;
         home_level_ff <= home_level_in;
      end
   end

   assign position_wide = 64'(position_in);

   always_comb begin
      result.step_level  = phase_in;
      result.direction   = dir_in;
      result.position    = position_wide[31:0];
      result.moving      = (position_in != target_in);
      result.homing_busy = homing_in;
   end

endmodule

`default_nettype wire

@@ hdl/stepper_step_dir_generator.sv @@
// stepper_step_dir_generator: top level with input register, result register and csr
// depends on sdg_pkg and sdg_core
`timescale 1ns / 1ps
`default_nettype none

// Step/direction generator with homing. Each request word is a one microsecond
// tick, a new absolute target or a homing request, and each gives exactly one
// response word carrying the state after it. A word is taken every clock while
// req_stall is low; an accepted word waits in the input register, the state update
// then writes the result register that gives the response, and rsp_stall holds the
// result register while the input register keeps one more word. The half period
// register is written through the csr port, ready only while no word is in flight.

module stepper_step_dir_generator
   import sdg_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire req_word_type                req_word,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output rsp_word_type                     rsp_word,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [HALF_PERIOD_BITS-1:0] csr_data
);

   logic                         in_valid_ff, in_valid_in;
   req_word_type                 in_word_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_word_type                 rsp_word_ff;
   logic [HALF_PERIOD_BITS-1:0]  half_period_ff;
   logic [HOMING_LIMIT_BITS-1:0] home_limit_ff;
   logic                         advance;
   logic                         req_fire;
   rsp_word_type                 core_result;

   assign advance     = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign req_fire    = req_valid && !req_stall;
   assign in_valid_in = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   assign csr_ready   = !in_valid_ff && !rsp_valid_ff;

   sdg_core #(
      .POSITION_BITS(POSITION_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .word       (in_word_ff),
      .half_period(half_period_ff),
      .home_limit (home_limit_ff),
      .result     (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         half_period_ff <= HALF_PERIOD_RESET;
         home_limit_ff  <= HOMING_LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            half_period_ff <= csr_data;
            home_limit_ff  <= homing_limit(csr_data);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         rsp_word_ff <= core_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_home_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.homing_busy |-> rsp_word_ff.direction)
      else $error("homing without clockwise direction");

   a_home_start: assert property (@(posedge clock) disable iff (reset)
      advance && (in_word_ff.operation == OP_HOME) |=>
         rsp_word_ff.homing_busy && rsp_word_ff.direction)
      else $error("homing request did not start a search");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_word_ff))
      else $error("input register lost a word");

endmodule

`default_nettype wire
